@@ sv/scms_pkg.sv @@
// package: request codes, frame constants and defaults for the sensor change message scheduler
`timescale 1ns / 1ps
`default_nettype none
package scms_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int VAL_W          = 10;
    localparam int SLOT_W         = 3;

    typedef logic [1:0] t_req;
    localparam t_req REQ_TOUCH   = 2'd0;
    localparam t_req REQ_RELEASE = 2'd1;
    localparam t_req REQ_SENSOR  = 2'd2;
    localparam t_req REQ_SEND    = 2'd3;

    localparam logic [VAL_W-1:0] SENSOR_FULL = 10'h3ff;
    localparam logic [7:0]       MSG_XY      = 8'h50;
    localparam logic [7:0]       MSG_RELEASE = 8'h70;

    function automatic logic [7:0] frame_id(input logic [SLOT_W-1:0] slot);
        logic [7:0] id;
        unique case (slot)
            3'd0, 3'd1: id = MSG_XY;
            3'd2:       id = MSG_RELEASE;
            3'd3:       id = 8'h84;
            3'd4:       id = 8'h90;
            3'd5:       id = 8'h94;
            3'd6:       id = 8'h98;
            3'd7:       id = 8'h9c;
            default:    id = 8'h9c;
        endcase
        return id;
    endfunction

endpackage
`default_nettype wire

@@ sv/sensor_change_message_scheduler_top.sv @@
// top level: slot memory, pending mask and round-robin message sequencer
// updates: a touch runs read and update for slot X, then for slot Y, then writes slot Z;
//   release and sensor updates run one read and update; send: three bytes for an xy frame,
//   two for a sensor frame, one for a release byte, none for an empty mask
// throughput: one request per busy period, set by the slot memory
//   read-modify-write sequence; results come one byte per cycle, the receiver cannot stall
// reset: synchronous active low, clears pending mask, cursor and slot valid bits (slots read as 0)
`timescale 1ns / 1ps
`default_nettype none
module sensor_change_message_scheduler_top #(
    parameter int SLOT_COUNT = scms_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    i_req_type,
    input  wire logic [scms_pkg::VAL_W-1:0]    i_x_value,
    input  wire logic [scms_pkg::VAL_W-1:0]    i_y_value,
    input  wire logic [scms_pkg::VAL_W-1:0]    i_z_value,
    input  wire logic [scms_pkg::SLOT_W-1:0]   i_slot_index,
    input  wire logic [scms_pkg::VAL_W-1:0]    i_sample_value,
    output logic                               o_strobe,
    output logic [7:0]                         o_tx_byte,
    output logic                               o_last_byte
);

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int VW = scms_pkg::VAL_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RD   = 4'd1;
    localparam logic [3:0] ST_UPD  = 4'd2;
    localparam logic [3:0] ST_ZWR  = 4'd3;
    localparam logic [3:0] ST_SEND = 4'd4;
    localparam logic [3:0] ST_XY0  = 4'd5;
    localparam logic [3:0] ST_XY1  = 4'd6;
    localparam logic [3:0] ST_SEN0 = 4'd7;
    localparam logic [3:0] ST_LAST = 4'd8;

    localparam logic [AW-1:0] SLOT_X = AW'(0);
    localparam logic [AW-1:0] SLOT_Y = AW'(1);
    localparam logic [AW-1:0] SLOT_Z = AW'(2);

    logic [VW-1:0] mem [SLOT_COUNT];
    logic [VW-1:0] r_rd_data;
    logic          r_rd_valid;

    logic [3:0]            r_state, n_state;
    logic [SLOT_COUNT-1:0] r_pending, n_pending;
    logic [SLOT_COUNT-1:0] r_valid, n_valid;
    logic [AW-1:0]         r_cursor, n_cursor;
    logic [1:0]            r_req, n_req;
    logic [AW-1:0]         r_addr, n_addr;
    logic [VW-1:0]         r_val, n_val;
    logic [VW-1:0]         r_y, n_y;
    logic [VW-1:0]         r_z, n_z;
    logic [VW-1:0]         r_x, n_x;
    logic [7:0]            r_lo, n_lo;
    logic                  r_strobe, n_strobe;
    logic [7:0]            r_byte, n_byte;
    logic                  r_last, n_last;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [VW-1:0] wr_data;

    logic [VW-1:0] old_val;
    logic [VW-1:0] merged;
    logic          found;
    logic [AW-1:0] pick;
    logic [AW:0]   cand_sum;
    logic [AW-1:0] cand;

    assign busy        = (r_state != ST_IDLE);
    assign o_strobe    = r_strobe;
    assign o_tx_byte   = r_byte;
    assign o_last_byte = r_last;

    assign old_val = r_rd_valid ? r_rd_data : '0;
    assign merged  = VW'({1'b0, r_val[VW-1:1]} + {1'b0, old_val[VW-1:1]});

    // next pending slot after the cursor, round robin
    always_comb begin
        found    = 1'b0;
        pick     = '0;
        cand_sum = '0;
        cand     = '0;
        for (int k = SLOT_COUNT; k >= 1; k--) begin
            cand_sum = {1'b0, r_cursor} + (AW+1)'(k);
            if (cand_sum >= (AW+1)'(SLOT_COUNT)) begin
                cand = AW'(cand_sum - (AW+1)'(SLOT_COUNT));
            end else begin
                cand = cand_sum[AW-1:0];
            end
            if (r_pending[cand]) begin
                found = 1'b1;
                pick  = cand;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_pending = r_pending;
        n_valid   = r_valid;
        n_cursor  = r_cursor;
        n_req     = r_req;
        n_addr    = r_addr;
        n_val     = r_val;
        n_y       = r_y;
        n_z       = r_z;
        n_x       = r_x;
        n_lo      = r_lo;
        n_strobe  = 1'b0;
        n_byte    = r_byte;
        n_last    = r_last;
        rd_en     = 1'b0;
        rd_addr   = r_addr;
        wr_en     = 1'b0;
        wr_addr   = r_addr;
        wr_data   = r_val;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_req = i_req_type;
                    n_y   = i_y_value;
                    n_z   = i_z_value;
                    unique case (i_req_type)
                        scms_pkg::REQ_TOUCH: begin
                            n_addr  = SLOT_X;
                            n_val   = i_x_value;
                            n_state = ST_RD;
                        end
                        scms_pkg::REQ_RELEASE: begin
                            n_addr  = SLOT_Z;
                            n_val   = scms_pkg::SENSOR_FULL;
                            n_state = ST_RD;
                        end
                        scms_pkg::REQ_SENSOR: begin
                            n_addr = AW'(i_slot_index);
                            n_val  = i_sample_value;
                            if ({1'b0, i_slot_index} < 4'(SLOT_COUNT)) begin
                                n_state = ST_RD;
                            end
                        end
                        scms_pkg::REQ_SEND: begin
                            n_state = ST_SEND;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_addr;
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if (old_val != r_val) begin
                    wr_en   = 1'b1;
                    wr_addr = r_addr;
                    wr_data = r_pending[r_addr] ? merged : r_val;
                    n_valid[r_addr]   = 1'b1;
                    n_pending[r_addr] = 1'b1;
                end
                n_state = ST_IDLE;
                if (r_req == scms_pkg::REQ_TOUCH) begin
                    if (r_addr == SLOT_X) begin
                        n_addr  = SLOT_Y;
                        n_val   = r_y;
                        n_state = ST_RD;
                    end else begin
                        n_state = ST_ZWR;
                    end
                end else if (r_req == scms_pkg::REQ_RELEASE) begin
                    n_pending[SLOT_X] = 1'b0;
                    n_pending[SLOT_Y] = 1'b0;
                end
            end
            ST_ZWR: begin
                wr_en   = 1'b1;
                wr_addr = SLOT_Z;
                wr_data = r_z;
                n_valid[SLOT_Z]   = 1'b1;
                n_pending[SLOT_Z] = 1'b0;
                n_state = ST_IDLE;
            end
            ST_SEND: begin
                n_state = ST_IDLE;
                if (found) begin
                    n_cursor = pick;
                    if (pick <= SLOT_Y) begin
                        rd_en   = 1'b1;
                        rd_addr = SLOT_X;
                        n_pending[SLOT_X] = 1'b0;
                        n_pending[SLOT_Y] = 1'b0;
                        n_state = ST_XY0;
                    end else if (pick == SLOT_Z) begin
                        n_pending[SLOT_Z] = 1'b0;
                        n_strobe = 1'b1;
                        n_byte   = scms_pkg::MSG_RELEASE;
                        n_last   = 1'b1;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = pick;
                        n_addr  = pick;
                        n_pending[pick] = 1'b0;
                        n_state = ST_SEN0;
                    end
                end
            end
            ST_XY0: begin
                n_x      = old_val;
                rd_en    = 1'b1;
                rd_addr  = SLOT_Y;
                n_strobe = 1'b1;
                n_byte   = scms_pkg::MSG_XY | {4'b0, old_val[9:6]};
                n_last   = 1'b0;
                n_state  = ST_XY1;
            end
            ST_XY1: begin
                n_lo     = old_val[7:0];
                n_strobe = 1'b1;
                n_byte   = {r_x[5:0], old_val[9:8]};
                n_last   = 1'b0;
                n_state  = ST_LAST;
            end
            ST_SEN0: begin
                n_lo     = old_val[7:0];
                n_strobe = 1'b1;
                n_byte   = scms_pkg::frame_id(scms_pkg::SLOT_W'(r_addr)) |
                           {6'b0, old_val[9:8]};
                n_last   = 1'b0;
                n_state  = ST_LAST;
            end
            ST_LAST: begin
                n_strobe = 1'b1;
                n_byte   = r_lo;
                n_last   = 1'b1;
                n_state  = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // slot memory, registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pending  <= '0;
            r_valid    <= '0;
            r_cursor   <= '0;
            r_strobe   <= 1'b0;
            r_rd_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_valid   <= n_valid;
            r_cursor  <= n_cursor;
            r_strobe  <= n_strobe;
            if (rd_en) begin
                r_rd_valid <= r_valid[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_addr <= n_addr;
        r_val  <= n_val;
        r_y    <= n_y;
        r_z    <= n_z;
        r_x    <= n_x;
        r_lo   <= n_lo;
        r_byte <= n_byte;
        r_last <= n_last;
    end

endmodule
`default_nettype wire

@@ sv/scms_checker.sv @@
// checker: port-level properties of the message scheduler, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module scms_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [1:0] i_req_type,
    input wire logic       o_strobe,
    input wire logic       o_last_byte
);

    // frame bytes come back to back
    a_frame_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_byte |=> o_strobe)
        else $error("frame interrupted before last byte");

    // a frame in progress keeps the block busy
    a_frame_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_byte |-> busy)
        else $error("idle while frame in progress");

    // an accepted request produces no byte in the following cycle
    a_no_early_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> !o_strobe)
        else $error("byte right after request");

    // a send request always occupies the block
    a_send_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_req_type == scms_pkg::REQ_SEND) |=> busy)
        else $error("send request not taken");

    // reset leaves the block idle and quiet
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_strobe)
        else $error("not idle after reset");

endmodule

bind sensor_change_message_scheduler_top scms_checker u_scms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_req_type  (i_req_type),
    .o_strobe    (o_strobe),
    .o_last_byte (o_last_byte)
);
`default_nettype wire
